/* hdl/button_tap_hold_detector_defines.svh */
// Assertion macros for the button tap/hold detector.
// Expects clk and rst to be in scope where a macro is used.
`ifndef BUTTON_TAP_HOLD_DETECTOR_DEFINES_SVH
`define BUTTON_TAP_HOLD_DETECTOR_DEFINES_SVH

// checked only outside reset
`define BTHD_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// checked on every edge, reset included
`define BTHD_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

/* hdl/bthd_pkg.sv */
// Shared types and constants for the button tap/hold detector.
// No dependencies.
`timescale 1ns / 1ps

package bthd_pkg;

  localparam int TIME_W  = 32;
  localparam int COUNT_W = 16;

  typedef logic [TIME_W-1:0]  time_t;
  typedef logic [COUNT_W-1:0] count_t;

  // operation codes carried on s_tuser
  localparam logic OP_SAMPLE = 1'b0;
  localparam logic OP_TICK   = 1'b1;

  // configuration register indexes
  localparam int CFG_INDEX_W = 3;
  typedef logic [CFG_INDEX_W-1:0] cfg_index_t;
  localparam cfg_index_t CFG_DETECT_TAP      = 3'd0;
  localparam cfg_index_t CFG_DETECT_HOLD     = 3'd1;
  localparam cfg_index_t CFG_DETECT_ON       = 3'd2;
  localparam cfg_index_t CFG_TAP_INTERVAL    = 3'd3;
  localparam cfg_index_t CFG_TAP_COUNT_LIMIT = 3'd4;
  localparam int CFG_DATA_W = 32;

  // stream packing
  localparam int IN_FIELDS_W  = 1 + TIME_W + 2;
  localparam int S_TDATA_W    = ((IN_FIELDS_W + 7) / 8) * 8;
  localparam int S_PAD_W      = S_TDATA_W - IN_FIELDS_W;
  localparam int OUT_FIELDS_W = 4 + COUNT_W + TIME_W;
  localparam int M_TDATA_W    = ((OUT_FIELDS_W + 7) / 8) * 8;
  localparam int M_PAD_W      = M_TDATA_W - OUT_FIELDS_W;

  typedef struct packed {
    logic  operation;
    logic  pressed;
    time_t event_time;
    logic  clear_tap_count;
    logic  clear_hold_time;
  } item_t;

  typedef struct packed {
    logic   changed;
    logic   tapping;
    logic   holding;
    logic   is_on;
    count_t tap_count;
    time_t  hold_time;
  } result_t;

endpackage

/* hdl/button_tap_hold_detector.sv */
// Button tap/hold detector top level: input register, state update, result register.
// Depends on bthd_pkg and button_tap_hold_detector_defines.svh.
`timescale 1ns / 1ps
// Usage:
//   Items (samples and timer ticks) enter on the s_ stream, one result per
//   item leaves on the m_ stream in the same order. s_tuser selects sample
//   (0) or tick (1).
//   Config is a separate write channel (cfg_valid/cfg_ready, cfg_index,
//   cfg_data); cfg_ready is always high. Indexes above four are dropped.
//   Write config only while no item is in flight.
//   Path: an item passes the input register, then the result register,
//   before its result is offered on m_.
//   Throughput: one item per cycle while m_tready does not stall the result
//   register, set by the combinational state update between the two
//   registers; an item may follow in the next cycle.
//   Stall: while the result register is held by m_tready low, the input
//   register still takes one more item; s_tready then drops until the
//   result is taken.
//   Reset (rst, synchronous): all config and tracking state go to zero,
//   both streams empty.
`include "button_tap_hold_detector_defines.svh"

module button_tap_hold_detector
  import bthd_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst,
  // slave stream
  input  logic                   s_tvalid,
  output logic                   s_tready,
  // s_tdata, LSB up: pressed, event_time[31:0], clear_tap_count,
  // clear_hold_time, zero padding
  input  logic [S_TDATA_W-1:0]   s_tdata,
  input  logic                   s_tuser,   // operation: 0 sample, 1 tick
  // master stream
  output logic                   m_tvalid,
  input  logic                   m_tready,
  // m_tdata, LSB up: changed, tapping, holding, is_on, tap_count[15:0],
  // hold_time[31:0], zero padding
  output logic [M_TDATA_W-1:0]   m_tdata,
  // config write channel
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data
);

  // config registers
  logic   detect_tap, detect_hold, detect_on;
  time_t  tap_interval;
  count_t tap_count_limit;

  // tracking state
  logic   tap_active, limit_hit, hold_active, on_state;
  count_t taps_seen;
  time_t  last_sample_time, hold_start_time, last_hold_length;

  logic   tap_active_next, limit_hit_next, hold_active_next, on_state_next;
  count_t taps_seen_next;
  time_t  last_sample_time_next, hold_start_time_next, last_hold_length_next;

  // pipeline registers
  logic    in_valid;
  item_t   in_q;
  result_t out_q;
  result_t res;

  logic advance, proc;

  assign cfg_ready = 1'b1;
  assign advance   = !m_tvalid || m_tready;
  assign proc      = in_valid && advance;
  assign s_tready  = !in_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      detect_tap      <= 1'b0;
      detect_hold     <= 1'b0;
      detect_on       <= 1'b0;
      tap_interval    <= '0;
      tap_count_limit <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_DETECT_TAP:      detect_tap      <= cfg_data[0];
        CFG_DETECT_HOLD:     detect_hold     <= cfg_data[0];
        CFG_DETECT_ON:       detect_on       <= cfg_data[0];
        CFG_TAP_INTERVAL:    tap_interval    <= cfg_data[TIME_W-1:0];
        CFG_TAP_COUNT_LIMIT: tap_count_limit <= cfg_data[COUNT_W-1:0];
        default: ;
      endcase
    end
  end

  // state update for the item in the input register
  logic  taps_on, first_tap, gap_over;
  time_t ref_time, gap;
  count_t count_clamped;

  always_comb begin
    tap_active_next       = tap_active;
    limit_hit_next        = limit_hit;
    hold_active_next      = hold_active;
    on_state_next         = on_state;
    taps_seen_next        = taps_seen;
    last_sample_time_next = last_sample_time;
    hold_start_time_next  = hold_start_time;
    last_hold_length_next = last_hold_length;
    res                   = '0;

    taps_on   = detect_tap && (tap_interval != '0);
    first_tap = (in_q.operation == OP_SAMPLE) && (taps_seen == '0);
    // a fresh tap run measures its gap from the sample itself
    ref_time  = first_tap ? in_q.event_time : last_sample_time;
    gap       = in_q.event_time - ref_time;
    gap_over  = gap > tap_interval;

    if (in_q.operation == OP_TICK) begin
      if (taps_on && tap_active && gap_over) begin
        tap_active_next = 1'b0;
        res.changed     = 1'b1;
      end
    end else begin
      if (taps_on) begin
        if (first_tap) limit_hit_next = 1'b0;
        if (in_q.pressed) begin
          tap_active_next = 1'b1;
          if (taps_seen != '1) taps_seen_next = taps_seen + 1'b1;
        end
        if (gap_over) tap_active_next = 1'b0;
        if (tap_active_next && (tap_count_limit != '0) &&
            (taps_seen_next > tap_count_limit))
          limit_hit_next = 1'b1;
        last_sample_time_next = in_q.event_time;
        if ((tap_active_next != tap_active) ||
            (limit_hit_next != (limit_hit && !first_tap)))
          res.changed = 1'b1;
      end
      if (detect_hold) begin
        if (in_q.pressed) begin
          hold_active_next     = 1'b1;
          hold_start_time_next = in_q.event_time;
        end else begin
          last_hold_length_next = in_q.event_time - hold_start_time;
          hold_active_next      = 1'b0;
        end
        if (hold_active_next != hold_active) res.changed = 1'b1;
      end
      if (detect_on) begin
        if (on_state != in_q.pressed) res.changed = 1'b1;
        on_state_next = in_q.pressed;
      end
    end

    count_clamped = taps_seen_next;
    if ((tap_count_limit != '0) && (taps_seen_next > tap_count_limit))
      count_clamped = tap_count_limit;

    res.tapping   = tap_active_next && !limit_hit_next;
    res.holding   = hold_active_next;
    res.is_on     = on_state_next;
    res.tap_count = count_clamped;

    // clears act after the values are reported
    if (in_q.clear_tap_count) taps_seen_next = '0;
    if (hold_active_next) begin
      res.hold_time = in_q.event_time - hold_start_time_next;
      if (in_q.clear_hold_time) hold_start_time_next = in_q.event_time;
    end else begin
      res.hold_time = last_hold_length_next;
      if (in_q.clear_hold_time) last_hold_length_next = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tap_active       <= 1'b0;
      limit_hit        <= 1'b0;
      hold_active      <= 1'b0;
      on_state         <= 1'b0;
      taps_seen        <= '0;
      last_sample_time <= '0;
      hold_start_time  <= '0;
      last_hold_length <= '0;
    end else if (proc) begin
      tap_active       <= tap_active_next;
      limit_hit        <= limit_hit_next;
      hold_active      <= hold_active_next;
      on_state         <= on_state_next;
      taps_seen        <= taps_seen_next;
      last_sample_time <= last_sample_time_next;
      hold_start_time  <= hold_start_time_next;
      last_hold_length <= last_hold_length_next;
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
    if (s_tvalid && s_tready) begin
      in_q.operation       <= s_tuser;
      in_q.pressed         <= s_tdata[0];
      in_q.event_time      <= s_tdata[TIME_W:1];
      in_q.clear_tap_count <= s_tdata[TIME_W+1];
      in_q.clear_hold_time <= s_tdata[TIME_W+2];
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (advance) begin
      m_tvalid <= in_valid;
    end
    if (proc) out_q <= res;
  end

  assign m_tdata = {{M_PAD_W{1'b0}}, out_q.hold_time, out_q.tap_count, out_q.is_on,
                    out_q.holding, out_q.tapping, out_q.changed};

  `BTHD_ASSERT_ALWAYS(a_reset_empties, rst |=> !in_valid && !m_tvalid, "streams not empty after reset")
  `BTHD_ASSERT(a_stall_only_when_full, !s_tready |-> in_valid && m_tvalid && !m_tready, "s_tready low without a full pipeline")
  `BTHD_ASSERT(a_tapping_matches_state, proc |=> out_q.tapping == (tap_active && !limit_hit), "tapping output disagrees with tap state")
  `BTHD_ASSERT(a_press_starts_hold, proc && (in_q.operation == OP_SAMPLE) && in_q.pressed && detect_hold |=> out_q.holding && hold_active, "press did not start a hold")

endmodule
